// ===== src/i2cmbe_pkg.sv =====
package i2cmbe_pkg;

	localparam int unsigned HalfDelayW     = 8;
	localparam logic [7:0]  HalfDelayReset = 8'd50;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] tx_byte;
		logic       sda_in;
	} in_word_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_enable;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       nack_seen;
	} out_word_t;

endpackage

// ===== src/i2cmbe_seq.sv =====
module i2cmbe_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            half_delay,
	input  i2cmbe_pkg::in_word_t  item,
	output i2cmbe_pkg::out_word_t res
);
	import i2cmbe_pkg::*;

	typedef enum logic [2:0] {
		CMD_IDLE      = 3'd0,
		CMD_START     = 3'd1,
		CMD_STOP      = 3'd2,
		CMD_WRITE     = 3'd3,
		CMD_READ_ACK  = 3'd4,
		CMD_READ_NACK = 3'd5
	} cmd_t;

	cmd_t       cmd_q, cmd_d;
	logic [2:0] phase_q, phase_d;
	logic [3:0] bits_q, bits_d, bits_inc;
	logic [7:0] wait_q, wait_d, wait_dec, hold_len;
	logic [7:0] shift_q, shift_d;
	logic [7:0] rx_q, rx_d;
	logic       ack_q, ack_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       en_q, en_d;
	logic       adv;
	logic       done;

	assign hold_len = (half_delay != 8'd0) ? half_delay : 8'd1;
	assign wait_dec = (wait_q != 8'd0) ? wait_q - 8'd1 : 8'd0;
	assign bits_inc = bits_q + 4'd1;

	always_comb begin
		cmd_d   = cmd_q;
		phase_d = phase_q;
		bits_d  = bits_q;
		wait_d  = wait_q;
		shift_d = shift_q;
		rx_d    = rx_q;
		ack_d   = ack_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		en_d    = en_q;
		adv     = 1'b0;
		done    = 1'b0;
		if (cmd_q == CMD_IDLE) begin
			if (item.func >= 3'(CMD_START) && item.func <= 3'(CMD_READ_NACK)) begin
				cmd_d   = cmd_t'(item.func);
				phase_d = 3'd0;
				bits_d  = 4'd0;
				wait_d  = hold_len;
				if (item.func == 3'(CMD_START)) begin
					sda_d = 1'b1;
					en_d  = 1'b1;
				end else if (item.func == 3'(CMD_STOP)) begin
					scl_d = 1'b0;
				end else if (item.func == 3'(CMD_WRITE)) begin
					shift_d = item.tx_byte;
				end else begin
					shift_d = 8'd0;
					en_d    = 1'b0;
				end
			end
		end else begin
			wait_d = wait_dec;
			if (wait_dec == 8'd0) begin
				unique case (cmd_q)
					CMD_START: begin
						adv = (phase_q < 3'd3);
						if (phase_q == 3'd0) scl_d = 1'b1;
						if (phase_q == 3'd1) sda_d = 1'b0;
						if (phase_q == 3'd2) scl_d = 1'b0;
						if (adv) phase_d = phase_q + 3'd1;
					end
					CMD_STOP: begin
						adv = (phase_q < 3'd3);
						if (phase_q == 3'd0) begin
							sda_d = 1'b0;
							en_d  = 1'b1;
						end
						if (phase_q == 3'd1) scl_d = 1'b1;
						if (phase_q == 3'd2) sda_d = 1'b1;
						if (adv) phase_d = phase_q + 3'd1;
					end
					CMD_WRITE: begin
						adv = 1'b1;
						unique case (phase_q)
							3'd0: phase_d = 3'd1;
							3'd1: begin
								sda_d   = shift_q[7];
								en_d    = 1'b1;
								phase_d = 3'd2;
							end
							3'd2: begin
								scl_d   = 1'b1;
								phase_d = 3'd3;
							end
							3'd3: begin
								scl_d   = 1'b0;
								phase_d = 3'd4;
							end
							3'd4: begin
								shift_d = {shift_q[6:0], 1'b0};
								bits_d  = bits_inc;
								if (bits_inc < 4'd8) begin
									phase_d = 3'd1;
								end else begin
									en_d    = 1'b0;
									phase_d = 3'd5;
								end
							end
							3'd5: begin
								scl_d   = 1'b1;
								ack_d   = item.sda_in;
								phase_d = 3'd6;
							end
							3'd6: begin
								scl_d   = 1'b0;
								phase_d = 3'd7;
							end
							default: adv = 1'b0;
						endcase
					end
					CMD_READ_ACK, CMD_READ_NACK: begin
						adv = 1'b1;
						unique case (phase_q)
							3'd0: phase_d = 3'd1;
							3'd1: begin
								scl_d   = 1'b1;
								phase_d = 3'd2;
							end
							3'd2: begin
								// sample on the end of SCL high
								shift_d = {shift_q[6:0], item.sda_in};
								bits_d  = bits_inc;
								scl_d   = 1'b0;
								if (bits_inc < 4'd8) begin
									phase_d = 3'd1;
								end else begin
									sda_d   = (cmd_q == CMD_READ_NACK);
									en_d    = 1'b1;
									phase_d = 3'd3;
								end
							end
							3'd3: begin
								scl_d   = 1'b1;
								phase_d = 3'd4;
							end
							3'd4: begin
								scl_d   = 1'b0;
								phase_d = 3'd5;
							end
							default: begin
								rx_d = shift_q;
								adv  = 1'b0;
							end
						endcase
					end
					default: adv = 1'b0;
				endcase
				if (adv) begin
					wait_d = hold_len;
				end else begin
					cmd_d   = CMD_IDLE;
					phase_d = 3'd0;
					bits_d  = 4'd0;
					done    = 1'b1;
				end
			end
		end
	end

	always_comb begin
		res.scl_level  = scl_d;
		res.sda_level  = sda_d;
		res.sda_enable = en_d;
		res.busy_res   = (cmd_d != CMD_IDLE);
		res.done_res   = done;
		res.rx_byte    = rx_d;
		res.nack_seen  = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= CMD_IDLE;
			phase_q <= 3'd0;
			bits_q  <= 4'd0;
			wait_q  <= 8'd0;
			shift_q <= 8'd0;
			rx_q    <= 8'd0;
			ack_q   <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			en_q    <= 1'b1;
		end else if (step) begin
			cmd_q   <= cmd_d;
			phase_q <= phase_d;
			bits_q  <= bits_d;
			wait_q  <= wait_d;
			shift_q <= shift_d;
			rx_q    <= rx_d;
			ack_q   <= ack_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			en_q    <= en_d;
		end
	end

endmodule

// ===== src/i2c_master_byte_engine_core.sv =====
// channel | direction | handshake           | word
// in      | in        | in_valid/in_stall   | in_data  (func, tx_byte, sda_in)
// out     | out       | out_valid/out_stall | out_data (pins, busy, done, rx, nack)
// cfg     | in        | cfg_we              | cfg_wdata (half_delay)
//
// One word per cycle sustained while out is not stalled; each word is one tick of the pin sequencer.
// Each word passes the input register, then the sequencer step into the output register.
// The input register takes one more word while the output word waits to be taken.
// Reset (arst_n low): idle, SCL high, SDA driven high, half_delay 50.
// Stall on out holds the output word and, once the input register is full, stalls in.
module i2c_master_byte_engine_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  i2cmbe_pkg::in_word_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output i2cmbe_pkg::out_word_t out_data,
	input  logic                  cfg_we,
	input  logic [i2cmbe_pkg::HalfDelayW-1:0] cfg_wdata
);
	import i2cmbe_pkg::*;

	logic                  valid_s1;
	in_word_t              data_s1;
	logic                  step;
	logic [HalfDelayW-1:0] half_delay_q;
	out_word_t             res;
	logic                  out_valid_q;
	out_word_t             out_q;

	assign step     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_delay_q <= HalfDelayReset;
		end else if (cfg_we) begin
			half_delay_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	i2cmbe_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.half_delay (half_delay_q),
		.item       (data_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== src/i2cmbe_chk.sv =====
module i2cmbe_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_stall,
	input i2cmbe_pkg::out_word_t out_data
);
	import i2cmbe_pkg::*;

	logic deliver;
	logic last_busy_q;

	assign deliver = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_busy_q <= 1'b0;
		end else if (deliver) begin
			last_busy_q <= out_data.busy_res;
		end
	end

	a_stall_keeps_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_stall_keeps_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("out_data changed while stalled");

	// a completion word closes a command that the previous word showed busy
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		deliver && out_data.done_res |-> last_busy_q)
		else $error("done without a running command");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done and busy in the same word");

endmodule

bind i2c_master_byte_engine_core i2cmbe_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== tb/sv/i2cmbe_tb_pkg.sv =====
package i2cmbe_tb_pkg;

	// func codes carried in each input word
	typedef enum logic [2:0] {
		CmdNone,
		CmdStart,
		CmdStop,
		CmdWrite,
		CmdReadAck,
		CmdReadNack,
		CmdSpare6,
		CmdSpare7
	} cmd_e;

endpackage

// ===== tb/sv/i2cmbe_checker.sv =====
module i2cmbe_checker
	import i2cmbe_pkg::*;
	import i2cmbe_tb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  in_word_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  out_word_t             out_data,
	input  logic                  cfg_we,
	input  logic [HalfDelayW-1:0] cfg_wdata,
	output int                    fails,
	output int                    pending
);

	logic [7:0] half_delay;
	cmd_e       cmd;
	logic [3:0] phase;
	logic [3:0] bit_cnt;
	logic [7:0] wait_cnt;
	logic [7:0] shifter;
	logic [7:0] rx_hold;
	logic       ack_bit;
	logic       scl;
	logic       sda;
	logic       sda_en;
	out_word_t  bus_words_q[$];
	out_word_t  want;
	int         miss_count;

	assign fails = miss_count;

	function automatic logic [7:0] hold_ticks();
		return (half_delay == '0) ? 8'd1 : half_delay;
	endfunction

	// Apply the next pin change; returns 0 once the command has nothing left to do.
	function automatic bit next_edge(input logic line_sda);
		case (cmd)
			CmdStart: begin
				case (phase)
					4'd0: begin scl = 1'b1; phase = 4'd1; end
					4'd1: begin sda = 1'b0; phase = 4'd2; end
					4'd2: begin scl = 1'b0; phase = 4'd3; end
					default: return 1'b0;
				endcase
			end
			CmdStop: begin
				case (phase)
					4'd0: begin sda = 1'b0; sda_en = 1'b1; phase = 4'd1; end
					4'd1: begin scl = 1'b1; phase = 4'd2; end
					4'd2: begin sda = 1'b1; phase = 4'd3; end
					default: return 1'b0;
				endcase
			end
			CmdWrite: begin
				case (phase)
					4'd0: phase = 4'd1;
					4'd1: begin sda = shifter[7]; sda_en = 1'b1; phase = 4'd2; end
					4'd2: begin scl = 1'b1; phase = 4'd3; end
					4'd3: begin scl = 1'b0; phase = 4'd4; end
					4'd4: begin
						shifter = {shifter[6:0], 1'b0};
						bit_cnt = bit_cnt + 4'd1;
						if (bit_cnt < 4'd8) begin
							phase = 4'd1;
						end else begin
							sda_en = 1'b0;
							phase = 4'd5;
						end
					end
					// ack sampled as SCL rises
					4'd5: begin scl = 1'b1; ack_bit = line_sda; phase = 4'd6; end
					4'd6: begin scl = 1'b0; phase = 4'd7; end
					default: return 1'b0;
				endcase
			end
			CmdReadAck, CmdReadNack: begin
				case (phase)
					4'd0: phase = 4'd1;
					4'd1: begin scl = 1'b1; phase = 4'd2; end
					4'd2: begin
						shifter = {shifter[6:0], line_sda};
						bit_cnt = bit_cnt + 4'd1;
						scl = 1'b0;
						if (bit_cnt < 4'd8) begin
							phase = 4'd1;
						end else begin
							sda = (cmd == CmdReadNack);
							sda_en = 1'b1;
							phase = 4'd3;
						end
					end
					4'd3: begin scl = 1'b1; phase = 4'd4; end
					4'd4: begin scl = 1'b0; phase = 4'd5; end
					default: begin
						rx_hold = shifter;
						return 1'b0;
					end
				endcase
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic out_word_t step_bus_engine(input in_word_t w);
		out_word_t o;
		o = '0;
		if (cmd == CmdNone) begin
			if (w.func >= CmdStart && w.func <= CmdReadNack) begin
				cmd = cmd_e'(w.func);
				phase = 4'd0;
				bit_cnt = 4'd0;
				wait_cnt = hold_ticks();
				case (cmd)
					CmdStart: begin sda = 1'b1; sda_en = 1'b1; end
					CmdStop: scl = 1'b0;
					CmdWrite: shifter = w.tx_byte;
					default: begin shifter = '0; sda_en = 1'b0; end
				endcase
			end
		end else begin
			if (wait_cnt != '0)
				wait_cnt = wait_cnt - 8'd1;
			if (wait_cnt == '0) begin
				if (next_edge(w.sda_in)) begin
					wait_cnt = hold_ticks();
				end else begin
					cmd = CmdNone;
					phase = 4'd0;
					bit_cnt = 4'd0;
					o.done_res = 1'b1;
				end
			end
		end
		o.scl_level = scl;
		o.sda_level = sda;
		o.sda_enable = sda_en;
		o.busy_res = (cmd != CmdNone);
		o.rx_byte = rx_hold;
		o.nack_seen = ack_bit;
		return o;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			miss_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_delay = HalfDelayReset;
			cmd = CmdNone;
			phase = '0;
			bit_cnt = '0;
			wait_cnt = '0;
			shifter = '0;
			rx_hold = '0;
			ack_bit = 1'b0;
			scl = 1'b1;
			sda = 1'b1;
			sda_en = 1'b1;
			bus_words_q.delete();
			miss_count = 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				half_delay = cfg_wdata;
			// pop before push: a word can never come out on its own input edge
			if (out_valid && !out_stall) begin
				if (bus_words_q.size() == 0) begin
					$error("output word %h with nothing outstanding", out_data);
					miss_count++;
				end else begin
					want = bus_words_q.pop_front();
					check_field("scl_level", 8'(want.scl_level),
						8'(out_data.scl_level));
					check_field("sda_level", 8'(want.sda_level),
						8'(out_data.sda_level));
					check_field("sda_enable", 8'(want.sda_enable),
						8'(out_data.sda_enable));
					check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
					check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
					check_field("rx_byte", want.rx_byte, out_data.rx_byte);
					check_field("nack_seen", 8'(want.nack_seen),
						8'(out_data.nack_seen));
				end
			end
			if (in_valid && !in_stall)
				bus_words_q.push_back(step_bus_engine(in_data));
			pending <= bus_words_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	import i2cmbe_pkg::*;
	import i2cmbe_tb_pkg::*;

	typedef enum {SdaLow, SdaHigh, SdaRand} sda_pick_e;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_word_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_word_t             out_data;
	logic                  cfg_we;
	logic [HalfDelayW-1:0] cfg_wdata;
	int                    fails;
	int                    pending;
	bit                    tx_lazy;
	bit                    tx_eager;
	bit                    rx_long_hold;

	i2c_master_byte_engine_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	i2cmbe_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fails     (fails),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#1_000_000;
		$display("tb_top failed");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic push_tick(input cmd_e f, input logic [7:0] tx, input logic sda_bit);
		int gap;
		if ($urandom_range(0, 63) == 0)
			tx_lazy = 1'($urandom_range(0, 1));
		gap = (tx_lazy && !tx_eager) ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{func: f, tx_byte: tx, sda_in: sda_bit};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic pad_ticks(input int n, input sda_pick_e pick);
		logic sda_bit;
		repeat (n) begin
			case (pick)
				SdaLow: sda_bit = 1'b0;
				SdaHigh: sda_bit = 1'b1;
				default: sda_bit = 1'($urandom_range(0, 1));
			endcase
			push_tick(CmdNone, 8'($urandom), sda_bit);
		end
	endtask

	task automatic random_traffic(input int n);
		cmd_e f;
		repeat (n) begin
			f = CmdNone;
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 15))
					0, 1: f = CmdStart;
					2, 3: f = CmdStop;
					4, 5, 6, 7, 8: f = CmdWrite;
					9, 10, 11: f = CmdReadAck;
					12, 13, 14: f = CmdReadNack;
					default: f = $urandom_range(0, 1) ? CmdSpare6 : CmdSpare7;
				endcase
			end
			push_tick(f, 8'($urandom), 1'($urandom_range(0, 1)));
		end
	endtask

	// Drain everything outstanding, then write half_delay.
	task automatic set_half_delay(input logic [7:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		tx_lazy = 1'b0;
		tx_eager = 1'b0;
		rx_long_hold = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// spare codes do nothing; start runs at the reset half_delay
		push_tick(CmdSpare7, 8'hFF, 1'b1);
		push_tick(CmdSpare6, 8'h00, 1'b0);
		push_tick(CmdStart, 8'h00, 1'b1);
		pad_ticks(4 * HalfDelayReset + 4, SdaRand);

		set_half_delay(8'd1);
		push_tick(CmdStart, 8'($urandom), 1'b0);
		pad_ticks(6, SdaRand);
		push_tick(CmdWrite, 8'h00, 1'b0);
		pad_ticks(40, SdaLow);
		push_tick(CmdWrite, 8'hFF, 1'b1);
		pad_ticks(40, SdaHigh);
		// second command lands while the write is busy and must be dropped
		push_tick(CmdWrite, 8'hA5, 1'b0);
		push_tick(CmdReadAck, 8'h5A, 1'b1);
		pad_ticks(40, SdaRand);
		push_tick(CmdReadAck, 8'h00, 1'b1);
		pad_ticks(30, SdaHigh);
		push_tick(CmdReadNack, 8'hFF, 1'b0);
		pad_ticks(30, SdaLow);
		push_tick(CmdReadNack, 8'($urandom), 1'b1);
		pad_ticks(30, SdaRand);
		push_tick(CmdStop, 8'($urandom), 1'b0);
		pad_ticks(6, SdaRand);

		set_half_delay(8'd0);
		random_traffic(150);

		// receiver parks for a long stretch while words keep coming
		set_half_delay(8'd1);
		tx_eager = 1'b1;
		rx_long_hold = 1'b1;
		random_traffic(200);
		tx_eager = 1'b0;

		set_half_delay(8'd2);
		random_traffic(100);
		set_half_delay(8'd3);
		random_traffic(100);
		set_half_delay(8'($urandom_range(4, 12)));
		random_traffic(150);

		set_half_delay(8'd1);
		random_traffic(100);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (fails == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin : drain
		int hold;
		bit rx_lazy;
		rx_lazy = 1'b0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 63) == 0)
				rx_lazy = 1'($urandom_range(0, 1));
			hold = rx_lazy ? $urandom_range(0, 7) : 0;
			if (rx_long_hold) begin
				hold = 200;
				rx_long_hold = 1'b0;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

endmodule
